// File: design/tlseq_pkg.sv
// Shared types, constants and lamp helper for the traffic light sequencer.
package tlseq_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_P0A = 2'd0;
    localparam logic [1:0] REG_P0B = 2'd1;
    localparam logic [1:0] REG_P1A = 2'd2;
    localparam logic [1:0] REG_P1B = 2'd3;

    // Reset values of the phase times (seconds)
    localparam logic [7:0] P0A_RESET = 8'd23;
    localparam logic [7:0] P0B_RESET = 8'd20;
    localparam logic [7:0] P1A_RESET = 8'd13;
    localparam logic [7:0] P1B_RESET = 8'd10;

    // Tick thresholds (50 ms ticks) and yellow tail length
    localparam logic [4:0] TICK_HALF = 5'd10;
    localparam logic [4:0] TICK_SEC  = 5'd20;
    localparam logic [7:0] TAIL_SECS = 8'd3;

    // Lamp masks, bit 0 is A red
    localparam logic [5:0] A_RED    = 6'b000001;
    localparam logic [5:0] A_YELLOW = 6'b000010;
    localparam logic [5:0] A_GREEN  = 6'b000100;
    localparam logic [5:0] B_RED    = 6'b001000;
    localparam logic [5:0] B_YELLOW = 6'b010000;
    localparam logic [5:0] B_GREEN  = 6'b100000;

    localparam int OUT_TDATA_W = 24;
    localparam int IN_TDATA_W  = 8;

    typedef struct packed {
        logic [7:0] p0a;
        logic [7:0] p0b;
        logic [7:0] p1a;
        logic [7:0] p1b;
    } cfg_t;

    typedef struct packed {
        logic       emergency_shown;
        logic [7:0] seconds_b;
        logic [7:0] seconds_a;
        logic [5:0] lamps;
    } res_t;

    // Yellow blink on the direction losing right of way
    function automatic logic [5:0] blink_lamps(
        input logic [5:0] lamps,
        input logic [7:0] cnt_a,
        input logic [7:0] cnt_b,
        input logic       dir,
        input logic       blink,
        input logic       lit
    );
        logic [5:0] l;
        l = lamps;
        if (cnt_b <= TAIL_SECS && !dir && blink)
        begin
            l = l & ~(A_GREEN | A_YELLOW);
            if (lit)
                l = l | A_YELLOW;
        end
        if (cnt_a <= TAIL_SECS && dir && blink)
        begin
            l = l & ~(B_GREEN | B_YELLOW);
            if (lit)
                l = l | B_YELLOW;
        end
        return l;
    endfunction

endpackage

// File: design/tlseq_cfg.sv
// Configuration register file holding the four phase times.
module tlseq_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                we,
    input  logic [1:0]          index,
    input  logic [7:0]          data,
    output tlseq_pkg::cfg_t     cfg
);
    import tlseq_pkg::*;

    cfg_t cfg_reg;

    // Write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.p0a <= P0A_RESET;
            cfg_reg.p0b <= P0B_RESET;
            cfg_reg.p1a <= P1A_RESET;
            cfg_reg.p1b <= P1B_RESET;
        end
        else if (we)
        begin
            case (index)
                REG_P0A: cfg_reg.p0a <= data;
                REG_P0B: cfg_reg.p0b <= data;
                REG_P1A: cfg_reg.p1a <= data;
                REG_P1B: cfg_reg.p1b <= data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/tlseq_core.sv
// Sequencer state and single-pass next-state logic for one tick.
module tlseq_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                emergency,
    input  tlseq_pkg::cfg_t     cfg,
    output tlseq_pkg::res_t     res
);
    import tlseq_pkg::*;

    logic [4:0] tick_reg, tick_next;
    logic [7:0] cnt_a_reg, cnt_a_next;
    logic [7:0] cnt_b_reg, cnt_b_next;
    logic       phase_reg, phase_next;
    logic       dir_reg, dir_next;
    logic       blink_reg, blink_next;
    logic       resume_reg, resume_next;
    logic       emerg_reg, emerg_next;
    logic [5:0] lamps_reg, lamps_next;

    logic [5:0] lamps_base;
    logic [4:0] tick_inc;
    logic [7:0] dec_a, dec_b, tail_a, tail_b;
    logic       tail_a_hit, tail_b_hit;

    // Next state for one tick
    always_comb
    begin
        tick_next   = tick_reg;
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        phase_next  = phase_reg;
        dir_next    = dir_reg;
        blink_next  = blink_reg;
        resume_next = resume_reg;
        emerg_next  = emerg_reg;
        lamps_next  = lamps_reg;

        // release restores the phase-zero lamps and restarts the tick count
        lamps_base = resume_reg ? (A_GREEN | B_RED) : lamps_reg;
        tick_inc   = resume_reg ? 5'd0 : tick_reg + 5'd1;

        // second boundary: decrement, blink lit, yellow tail reload
        dec_a      = cnt_a_reg - 8'd1;
        dec_b      = cnt_b_reg - 8'd1;
        tail_a_hit = (dec_a == 8'd0) && (dec_b == TAIL_SECS);
        tail_a     = tail_a_hit ? TAIL_SECS : dec_a;
        tail_b_hit = (tail_a == TAIL_SECS) && (dec_b == 8'd0);
        tail_b     = tail_b_hit ? TAIL_SECS : dec_b;

        if (emergency)
        begin
            emerg_next  = 1'b1;
            phase_next  = 1'b0;
            lamps_next  = A_RED | B_RED;
            cnt_a_next  = cfg.p0a;
            cnt_b_next  = cfg.p0b;
            tick_next   = 5'd0;
            resume_next = 1'b1;
            blink_next  = 1'b0;
            dir_next    = 1'b0;
        end
        else
        begin
            emerg_next  = 1'b0;
            resume_next = 1'b0;
            lamps_next  = lamps_base;
            tick_next   = tick_inc;
            if (tick_inc == TICK_HALF)
            begin
                lamps_next = blink_lamps(lamps_base, cnt_a_reg, cnt_b_reg,
                                         dir_reg, blink_reg, 1'b0);
            end
            else if (tick_inc == TICK_SEC)
            begin
                tick_next  = 5'd0;
                lamps_next = blink_lamps(lamps_base, dec_a, dec_b,
                                         dir_reg, blink_reg, 1'b1);
                cnt_a_next = tail_a;
                cnt_b_next = tail_b;
                blink_next = blink_reg | tail_a_hit | tail_b_hit;
                // both expired: swap phase
                if (tail_a == 8'd0 && tail_b == 8'd0)
                begin
                    if (!phase_reg)
                    begin
                        lamps_next = A_RED | B_GREEN;
                        cnt_a_next = cfg.p1a;
                        cnt_b_next = cfg.p1b;
                    end
                    else
                    begin
                        lamps_next = A_GREEN | B_RED;
                        cnt_a_next = cfg.p0a;
                        cnt_b_next = cfg.p0b;
                    end
                    phase_next = !phase_reg;
                    dir_next   = !dir_reg;
                    blink_next = 1'b0;
                end
            end
        end
    end

    // State registers, updated once per tick request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= 5'd0;
            cnt_a_reg  <= P0A_RESET;
            cnt_b_reg  <= P0B_RESET;
            phase_reg  <= 1'b0;
            dir_reg    <= 1'b0;
            blink_reg  <= 1'b0;
            resume_reg <= 1'b0;
            emerg_reg  <= 1'b0;
            lamps_reg  <= A_GREEN | B_RED;
        end
        else if (step)
        begin
            tick_reg   <= tick_next;
            cnt_a_reg  <= cnt_a_next;
            cnt_b_reg  <= cnt_b_next;
            phase_reg  <= phase_next;
            dir_reg    <= dir_next;
            blink_reg  <= blink_next;
            resume_reg <= resume_next;
            emerg_reg  <= emerg_next;
            lamps_reg  <= lamps_next;
        end
    end

    // Result is the state as it stands after the tick
    assign res.lamps           = lamps_next;
    assign res.seconds_a       = cnt_a_next;
    assign res.seconds_b       = cnt_b_next;
    assign res.emergency_shown = emerg_next;

endmodule

// File: design/two_way_traffic_light_sequencer_unit.sv
// An accepted tick request passes through the input register and then the result register to the master side.
// Throughput: one tick per cycle while m_tready holds; input register -> tick logic -> result register.
// Backpressure: the input register stalls only while a result waits on m_tready.
// Reset (rst_n low, async): both channels empty, phase zero, lamps A green / B red,
// countdowns at 23 and 20, phase times back to 23, 20, 13, 10.
module two_way_traffic_light_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [tlseq_pkg::IN_TDATA_W-1:0]  s_tdata,   // [0] emergency, [7:1] zero
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] lamp_a_red [1] lamp_a_yellow [2] lamp_a_green [3] lamp_b_red
    // [4] lamp_b_yellow [5] lamp_b_green [13:6] seconds_a [21:14] seconds_b
    // [22] emergency_shown [23] zero
    output logic [tlseq_pkg::OUT_TDATA_W-1:0] m_tdata,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import tlseq_pkg::*;

    cfg_t cfg;
    res_t res;

    logic in_valid_reg;
    logic in_emerg_reg;
    logic out_valid_reg;
    res_t out_res_reg;
    logic advance;

    tlseq_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    tlseq_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .emergency (in_emerg_reg),
        .cfg       (cfg),
        .res       (res)
    );

    // Move a request forward when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_emerg_reg <= s_tdata[0];
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg};

endmodule

// File: design/tlseq_checker.sv
// Port-level checks for the traffic light sequencer, bound to the top level.
module tlseq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    // Held result stays put while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Input side only stalls behind a waiting result
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Emergency display shows both reds and nothing else
    a_emerg_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[22] |-> m_tdata[5:0] == 6'b001001)
        else $error("emergency pattern wrong");

    // Never green in both directions
    a_no_dual_green: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[2] && m_tdata[5]))
        else $error("both directions green");

endmodule

bind two_way_traffic_light_sequencer_unit tlseq_checker u_tlseq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
